// ----- sv/rhc_pkg.sv -----
// Shared constants, types and stage words for the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

   localparam int CHANNEL_BITS      = 8;
   localparam int HUE_FRACTION_BITS = 6;

   localparam int HUE_BITS   = 9 + HUE_FRACTION_BITS;
   localparam int CHAN_MAX   = (1 << CHANNEL_BITS) - 1;
   localparam int HUE_TURN   = 360 << HUE_FRACTION_BITS;
   // divisors are 2*max or 2*delta
   localparam int DEN_BITS   = CHANNEL_BITS + 1;
   localparam int QUO_BITS   = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
   localparam int NUM_BITS   = DEN_BITS + QUO_BITS;
   // signed angle*delta, below 360*2^CHANNEL_BITS in magnitude
   localparam int ANGLE_BITS = CHANNEL_BITS + 11;

   typedef logic [CHANNEL_BITS-1:0]      chan_type;
   typedef logic [DEN_BITS-1:0]          den_type;
   typedef logic [NUM_BITS-1:0]          num_type;
   typedef logic [QUO_BITS-1:0]          quo_type;
   typedef logic signed [ANGLE_BITS-1:0] angle_type;

   localparam angle_type DEG_60  = ANGLE_BITS'(60);
   localparam angle_type DEG_120 = ANGLE_BITS'(120);
   localparam angle_type DEG_240 = ANGLE_BITS'(240);
   localparam angle_type DEG_360 = ANGLE_BITS'(360);

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // word handed from the front end to the divider pipe
   typedef struct packed {
      num_type  hue_num;
      den_type  hue_den;
      num_type  sat_num;
      den_type  sat_den;
      chan_type brightness;
      logic     achromatic;
   } rhc_div_word_type;

   // one divider stage: partial remainders and quotients so far
   typedef struct packed {
      num_type  hue_rem;
      quo_type  hue_quo;
      den_type  hue_den;
      num_type  sat_rem;
      quo_type  sat_quo;
      den_type  sat_den;
      chan_type brightness;
      logic     achromatic;
   } rhc_div_stage_type;

endpackage

`default_nettype wire

// ----- sv/rhc_front.sv -----
// Front end: max/min/sector stage, then angle and divider operand stage.
`default_nettype none

module rhc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire rhc_pkg::chan_type         in_red,
   input  wire rhc_pkg::chan_type         in_green,
   input  wire rhc_pkg::chan_type         in_blue,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output rhc_pkg::rhc_div_word_type      out_word
);
   import rhc_pkg::*;

   typedef struct packed {
      chan_type   red;
      chan_type   green;
      chan_type   blue;
      chan_type   mx;
      chan_type   delta;
      sector_type sector;
   } stage_a_type;

   logic              a_vld_ff, b_vld_ff;
   logic              a_en, b_en;
   stage_a_type       a_in, a_ff;
   rhc_div_word_type  b_in, b_ff;

   chan_type          mx, mn;
   logic signed [CHANNEL_BITS:0] diff;
   angle_type         delta_s, base, t_raw, t_wrap;

   assign b_en     = !b_vld_ff || out_ready;
   assign a_en     = !a_vld_ff || b_en;
   assign in_ready = a_en;

   // stage A
   always_comb begin
      mx = in_red;
      mn = in_red;
      if (in_green > mx) mx = in_green;
      if (in_blue  > mx) mx = in_blue;
      if (in_green < mn) mn = in_green;
      if (in_blue  < mn) mn = in_blue;
      a_in.red   = in_red;
      a_in.green = in_green;
      a_in.blue  = in_blue;
      a_in.mx    = mx;
      a_in.delta = mx - mn;
      if (mx == in_red)        a_in.sector = SECTOR_RED;
      else if (mx == in_green) a_in.sector = SECTOR_GREEN;
      else                     a_in.sector = SECTOR_BLUE;
   end

   // stage B: angle times delta, wrapped to non-negative
   always_comb begin
      delta_s = $signed({{(ANGLE_BITS-CHANNEL_BITS){1'b0}}, a_ff.delta});
      case (a_ff.sector)
         SECTOR_RED: begin
            diff = $signed({1'b0, a_ff.green}) - $signed({1'b0, a_ff.blue});
            base = '0;
         end
         SECTOR_GREEN: begin
            diff = $signed({1'b0, a_ff.blue}) - $signed({1'b0, a_ff.red});
            base = DEG_120 * delta_s;
         end
         SECTOR_BLUE: begin
            diff = $signed({1'b0, a_ff.red}) - $signed({1'b0, a_ff.green});
            base = DEG_240 * delta_s;
         end
         default: begin
            diff = '0;
            base = '0;
         end
      endcase
      t_raw  = base + DEG_60 * ANGLE_BITS'(diff);
      t_wrap = (t_raw < 0) ? t_raw + DEG_360 * delta_s : t_raw;

      b_in.hue_num    = (NUM_BITS'($unsigned(t_wrap)) << (HUE_FRACTION_BITS + 1))
                        + NUM_BITS'(a_ff.delta);
      b_in.hue_den    = {a_ff.delta, 1'b0};
      b_in.sat_num    = ((NUM_BITS'(a_ff.delta) * NUM_BITS'(CHAN_MAX)) << 1)
                        + NUM_BITS'(a_ff.mx);
      b_in.sat_den    = {a_ff.mx, 1'b0};
      b_in.brightness = a_ff.mx;
      b_in.achromatic = (a_ff.delta == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (a_en) a_vld_ff <= in_valid;
         if (b_en) b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en && in_valid) a_ff <= a_in;
      if (b_en && a_vld_ff) b_ff <= b_in;
   end

   assign out_valid = b_vld_ff;
   assign out_word  = b_ff;

endmodule

`default_nettype wire

// ----- sv/rhc_div_pipe.sv -----
// Restoring divider pipe, one quotient bit per stage, hue and saturation side by side.
`default_nettype none

module rhc_div_pipe (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire rhc_pkg::rhc_div_word_type in_word,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output rhc_pkg::rhc_div_stage_type     out_stage
);
   import rhc_pkg::*;

   rhc_div_stage_type       st_ff [QUO_BITS];
   rhc_div_stage_type       st_in [QUO_BITS];
   rhc_div_stage_type       src;
   logic [QUO_BITS-1:0]     vld_ff;
   logic [QUO_BITS-1:0]     en;
   num_type                 hue_trial, sat_trial;

   // stage s loads when empty or when the stage after it moves
   always_comb begin
      for (int s = QUO_BITS - 1; s >= 0; s--) begin
         if (s == QUO_BITS - 1) en[s] = !vld_ff[s] || out_ready;
         else                   en[s] = !vld_ff[s] || en[s+1];
      end
   end

   assign in_ready = en[0];

   always_comb begin
      for (int s = 0; s < QUO_BITS; s++) begin
         if (s == 0) begin
            src.hue_rem    = in_word.hue_num;
            src.hue_quo    = '0;
            src.hue_den    = in_word.hue_den;
            src.sat_rem    = in_word.sat_num;
            src.sat_quo    = '0;
            src.sat_den    = in_word.sat_den;
            src.brightness = in_word.brightness;
            src.achromatic = in_word.achromatic;
         end else begin
            src = st_ff[s-1];
         end
         hue_trial = NUM_BITS'(src.hue_den) << (QUO_BITS - 1 - s);
         sat_trial = NUM_BITS'(src.sat_den) << (QUO_BITS - 1 - s);
         st_in[s] = src;
         if (src.hue_rem >= hue_trial) begin
            st_in[s].hue_rem = src.hue_rem - hue_trial;
            st_in[s].hue_quo[QUO_BITS-1-s] = 1'b1;
         end
         if (src.sat_rem >= sat_trial) begin
            st_in[s].sat_rem = src.sat_rem - sat_trial;
            st_in[s].sat_quo[QUO_BITS-1-s] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < QUO_BITS; s++) begin
            if (en[s]) vld_ff[s] <= (s == 0) ? in_valid : vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < QUO_BITS; s++) begin
         if (en[s]) st_ff[s] <= st_in[s];
      end
   end

   assign out_valid = vld_ff[QUO_BITS-1];
   assign out_stage = st_ff[QUO_BITS-1];

endmodule

`default_nettype wire

// ----- sv/rgb_to_hsv_converter_unit.sv -----
// Top level of the pipelined RGB to HSV converter.
// Usage:
//   req_ channel: one RGB pixel word (req_red, req_green, req_blue) per
//   valid/ready handshake. rsp_ channel: one HSV word per pixel, in order:
//   hue in 1/64 degree (0..23039), saturation 0..255, brightness = largest
//   channel, achromatic set when all channels are equal (hue, sat = 0).
//   Throughput: one pixel per clock, sustained, when rsp_ready stays high.
//   Depth: QUO_BITS + 3 register stages (18 at the default widths): two
//   front-end stages (max/min/sector, then angle and divider operands), one
//   restoring-divider stage per quotient bit, and the output register.
//   The divider depth sets the latency.
//   Each stage has its own valid bit and loads when empty or when the next
//   stage moves, so bubbles close up and req_ready stays high while the
//   output word waits, until the pipe is full.
//   Stall: a held rsp_ready keeps the output word steady; nothing is lost
//   or repeated. Reset (synchronous, active high) empties every stage; no
//   other state exists.
`default_nettype none

module rgb_to_hsv_converter_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [rhc_pkg::CHANNEL_BITS-1:0] req_red,
   input  wire logic [rhc_pkg::CHANNEL_BITS-1:0] req_green,
   input  wire logic [rhc_pkg::CHANNEL_BITS-1:0] req_blue,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [rhc_pkg::HUE_BITS-1:0]         rsp_hue,
   output logic [rhc_pkg::CHANNEL_BITS-1:0]     rsp_saturation,
   output logic [rhc_pkg::CHANNEL_BITS-1:0]     rsp_brightness,
   output logic                                 rsp_achromatic
);
   import rhc_pkg::*;

   rhc_div_word_type   front_word;
   logic               front_valid, front_ready;
   rhc_div_stage_type  div_stage;
   logic               div_valid, div_ready;

   logic               rsp_valid_ff;
   logic [HUE_BITS-1:0]     hue_in, hue_ff;
   logic [CHANNEL_BITS-1:0] sat_in, sat_ff, bright_ff;
   logic               achro_ff;
   logic               out_en;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_word  (front_word)
   );

   rhc_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_stage (div_stage)
   );

   // output register parts the divider from the receiver
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign div_ready = out_en;

   // a hue that rounds to a full turn reads as zero; equal channels zero both
   always_comb begin
      if (div_stage.achromatic || div_stage.hue_quo >= QUO_BITS'(HUE_TURN)) begin
         hue_in = '0;
      end else begin
         hue_in = div_stage.hue_quo[HUE_BITS-1:0];
      end
      sat_in = div_stage.achromatic ? '0 : div_stage.sat_quo[CHANNEL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && div_valid) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= div_stage.brightness;
         achro_ff  <= div_stage.achromatic;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;
   assign rsp_achromatic = achro_ff;

   // an empty output register means every stage can move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with output register empty");

   a_achromatic_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_achromatic) |-> (rsp_hue == '0 && rsp_saturation == '0))
      else $error("achromatic word with nonzero hue or saturation");

   a_hue_below_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue < HUE_BITS'(HUE_TURN)))
      else $error("hue at or beyond a full turn");

   a_chroma_needs_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_achromatic) |-> (rsp_brightness != '0))
      else $error("chromatic word with zero brightness");

endmodule

`default_nettype wire
